@@ hdl/nearest_and_radius_point_search_top_assert.svh @@
// Assertion macros shared by the checker files.
// Both macros expect signals named clk and arst_n where they are used.
`ifndef NEAREST_AND_RADIUS_POINT_SEARCH_TOP_ASSERT_SVH
`define NEAREST_AND_RADIUS_POINT_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define NRPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrps assertion failed");

// Next-cycle implication.
`define NRPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrps assertion failed");

`endif

@@ hdl/nrps_pkg.sv @@
package nrps_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int MAX_VERTICES = 255;

	localparam int COORD_W  = 31;
	localparam int SUM_W    = 39;
	localparam int TALLY_W  = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W    = $clog2(TABLE_DEPTH);
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int REQ_W    = 2;
	localparam int K_W      = 7;
	localparam int RAD_W    = 32;
	localparam int ST_W     = 2;
	localparam int OIDX_W   = 6;
	localparam int DIST_W   = 32;
	localparam int D2_W     = 64;
	localparam int DCNT_W   = $clog2(SUM_W + 1);
	localparam int SQ_STEPS = 32;
	localparam int SCNT_W   = $clog2(SQ_STEPS + 1);

	// Stream word layout.
	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 40;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_KNN    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RADIUS = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE = 2'd2;
	localparam logic [ST_W-1:0] ST_OVF  = 2'd3;

	typedef struct packed {
		logic            accept;
		logic            cent_load;
		logic            scan_init;
		logic            ins_write;
		logic            out_mode;
		logic            ins;
		logic            out_init;
		logic            sqrt_start;
		logic            emit_pt;
		logic            emit_one;
		logic [ST_W-1:0] one_status;
		logic            one_ins;
		logic            one_clr;
	} nrps_cmd_t;

	typedef struct packed {
		logic             div_busy;
		logic             ovf;
		logic [REQ_W-1:0] req;
		logic             full;
		logic             empty;
		logic             scan_last;
		logic             out_none;
		logic             out_last;
		logic             sqrt_busy;
		logic             out_free;
	} nrps_sts_t;

endpackage

@@ hdl/nearest_and_radius_point_search_top.sv @@
// Centroid point table with nearest-k and radius search. Each input word carries one
// vertex of an object; the word marked with tlast closes the object, its centroid (vertex
// sum over vertex count, truncated toward zero) is formed, and the request in tuser runs:
// insert the centroid into the next free table slot, return the k nearest stored points in
// ascending distance (ties to the lower index), return every point within the radius
// ordered by x and then by index, or clear the table. Objects of more than MAX_VERTICES
// vertices give a single result with the too-many-vertices status. Each returned point
// reports its table index and the floor of the Euclidean distance in the coordinate units.
// Vertices that do not close an object are taken back to back. A closing vertex goes
// through the centroid divider, which produces one quotient bit per cycle, and the
// centroid is then loaded. An insert then writes the table and gives its result; a clear
// or a single status result goes straight out. A query scans the table, each stored point
// passing table read, difference, square, sum and sorted insertion, then sets up the
// output run and, for each returned point, reads it again, forms its distance and takes
// the root in the bit-serial square root unit shared by all results. A stalled output
// holds the block back. The block takes no new word until the last result of a
// request has been handed to the output register, and needs no clearing pass after reset.
module nearest_and_radius_point_search_top import nrps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [30:0] vertex_x, [61:31] vertex_y, [68:62] neighbor_count,
	// [100:69] search_radius, [103:101] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	// [1:0] req_type
	input  logic [REQ_W-1:0]    s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [5:0] match_index, [37:6] match_distance, [39:38] zero
	output logic [M_DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [ST_W-1:0]     m_tuser,
	output logic                m_tlast
);

	nrps_cmd_t cmd;
	nrps_sts_t sts;
	logic [OIDX_W-1:0] match_index;
	logic [DIST_W-1:0] match_distance;

	// The controller sequences the request; it sees only status flags from the datapath.
	nrps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the sums, divider, point table, distance pipeline, the sorted
	// candidate cells, the square root unit and the output register.
	nrps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_req       (s_tuser),
		.in_x         (s_tdata[30:0]),
		.in_y         (s_tdata[61:31]),
		.in_last      (s_tlast),
		.in_k         (s_tdata[68:62]),
		.in_radius    (s_tdata[100:69]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_status   (m_tuser),
		.out_index    (match_index),
		.out_distance (match_distance),
		.out_last     (m_tlast)
	);

	// The padding bits of the output word are always zero.
	assign m_tdata = {2'b00, match_distance, match_index};

endmodule

@@ hdl/nrps_ram.sv @@
module nrps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/nrps_ctrl.sv @@
module nrps_ctrl import nrps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  nrps_sts_t sts,
	output nrps_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_FIN  = 4'd2;
	localparam logic [3:0] S_INSW = 4'd3;
	localparam logic [3:0] S_ONE  = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_DF   = 4'd6;
	localparam logic [3:0] S_ML   = 4'd7;
	localparam logic [3:0] S_AD   = 4'd8;
	localparam logic [3:0] S_INS  = 4'd9;
	localparam logic [3:0] S_OINI = 4'd10;
	localparam logic [3:0] S_SQ0  = 4'd11;
	localparam logic [3:0] S_SQW  = 4'd12;
	localparam logic [3:0] S_EM   = 4'd13;

	logic [3:0]      state_q, state_d;
	logic            mode_q, mode_d;
	logic [ST_W-1:0] one_st_q, one_st_d;
	logic            one_ins_q, one_ins_d;
	logic            one_clr_q, one_clr_d;

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		one_st_d  = one_st_q;
		one_ins_d = one_ins_q;
		one_clr_d = one_clr_q;
		cmd       = '0;
		cmd.out_mode   = mode_q;
		cmd.one_status = one_st_q;
		cmd.one_ins    = one_ins_q;
		cmd.one_clr    = one_clr_q;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_last) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.cent_load = 1'b1;
				cmd.scan_init = 1'b1;
				mode_d    = 1'b0;
				one_ins_d = 1'b0;
				one_clr_d = 1'b0;
				state_d   = S_ONE;
				if (sts.ovf) begin
					one_st_d = ST_OVF;
				end else begin
					case (sts.req)
						REQ_INSERT: begin
							if (sts.full) begin
								one_st_d = ST_FULL;
							end else begin
								one_st_d  = ST_OK;
								one_ins_d = 1'b1;
								state_d   = S_INSW;
							end
						end
						REQ_CLEAR: begin
							one_st_d  = ST_OK;
							one_clr_d = 1'b1;
						end
						default: begin
							one_st_d = ST_NONE;
							if (!sts.empty) begin
								state_d = S_RD;
							end
						end
					endcase
				end
			end
			S_INSW: begin
				cmd.ins_write = 1'b1;
				state_d = S_ONE;
			end
			S_ONE: begin
				if (sts.out_free) begin
					cmd.emit_one = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD: state_d = S_DF;
			S_DF: state_d = S_ML;
			S_ML: state_d = S_AD;
			S_AD: state_d = mode_q ? S_SQ0 : S_INS;
			S_INS: begin
				cmd.ins = 1'b1;
				state_d = sts.scan_last ? S_OINI : S_RD;
			end
			S_OINI: begin
				cmd.out_init = 1'b1;
				if (sts.out_none) begin
					one_st_d = ST_NONE;
					state_d  = S_ONE;
				end else begin
					mode_d  = 1'b1;
					state_d = S_RD;
				end
			end
			S_SQ0: begin
				cmd.sqrt_start = 1'b1;
				state_d = S_SQW;
			end
			S_SQW: begin
				if (!sts.sqrt_busy) begin
					state_d = S_EM;
				end
			end
			S_EM: begin
				if (sts.out_free) begin
					cmd.emit_pt = 1'b1;
					state_d = sts.out_last ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= 1'b0;
			one_st_q  <= ST_OK;
			one_ins_q <= 1'b0;
			one_clr_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			one_st_q  <= one_st_d;
			one_ins_q <= one_ins_d;
			one_clr_q <= one_clr_d;
		end
	end

endmodule

@@ hdl/nrps_dp.sv @@
module nrps_dp import nrps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nrps_cmd_t                 cmd,
	output nrps_sts_t                 sts,
	input  logic [REQ_W-1:0]          in_req,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic                      in_last,
	input  logic [K_W-1:0]            in_k,
	input  logic [RAD_W-1:0]          in_radius,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [ST_W-1:0]           out_status,
	output logic [OIDX_W-1:0]         out_index,
	output logic [DIST_W-1:0]         out_distance,
	output logic                      out_last
);

	// Request fields.
	logic [REQ_W-1:0] req_q;
	logic [K_W-1:0]   k_q;
	logic [RAD_W-1:0] radius_q;
	logic [D2_W-1:0]  rsq_q;

	// Vertex accumulation.
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_x_nx, sum_y_nx;
	logic [TALLY_W-1:0]      tally_q, tally_nx;
	logic                    ovf_q, ovf_nx, ovf_req_q;

	always_comb begin
		sum_x_nx = sum_x_q;
		sum_y_nx = sum_y_q;
		tally_nx = tally_q;
		ovf_nx   = ovf_q;
		if (tally_q < TALLY_W'(MAX_VERTICES)) begin
			sum_x_nx = sum_x_q + SUM_W'(in_x);
			sum_y_nx = sum_y_q + SUM_W'(in_y);
			tally_nx = tally_q + TALLY_W'(1);
		end else begin
			ovf_nx = 1'b1;
		end
	end

	// Sign-magnitude restoring divider, one quotient bit per cycle for both axes.
	logic [SUM_W-1:0]   dvx_q, dvy_q;
	logic [TALLY_W-1:0] rmx_q, rmy_q, dvd_q;
	logic               negx_q, negy_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [TALLY_W:0]   shx, shy;
	logic               qx, qy;
	logic [SUM_W-1:0]   sgx, sgy;

	assign shx = {rmx_q, dvx_q[SUM_W-1]};
	assign shy = {rmy_q, dvy_q[SUM_W-1]};
	assign qx  = shx >= {1'b0, dvd_q};
	assign qy  = shy >= {1'b0, dvd_q};
	assign sgx = negx_q ? (~dvx_q + SUM_W'(1)) : dvx_q;
	assign sgy = negy_q ? (~dvy_q + SUM_W'(1)) : dvy_q;

	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [CNT_W-1:0]          count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			tally_q   <= '0;
			ovf_q     <= 1'b0;
			ovf_req_q <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			if (cmd.accept) begin
				if (in_last) begin
					sum_x_q   <= '0;
					sum_y_q   <= '0;
					tally_q   <= '0;
					ovf_q     <= 1'b0;
					ovf_req_q <= ovf_nx;
					dcnt_q    <= DCNT_W'(SUM_W);
				end else begin
					sum_x_q <= sum_x_nx;
					sum_y_q <= sum_y_nx;
					tally_q <= tally_nx;
					ovf_q   <= ovf_nx;
				end
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rsq_q <= D2_W'(radius_q) * D2_W'(radius_q);
		if (cmd.accept) begin
			req_q    <= in_req;
			k_q      <= in_k;
			radius_q <= in_radius;
			if (in_last) begin
				negx_q <= sum_x_nx[SUM_W-1];
				negy_q <= sum_y_nx[SUM_W-1];
				dvx_q  <= sum_x_nx[SUM_W-1] ? (~sum_x_nx + SUM_W'(1)) : sum_x_nx;
				dvy_q  <= sum_y_nx[SUM_W-1] ? (~sum_y_nx + SUM_W'(1)) : sum_y_nx;
				rmx_q  <= '0;
				rmy_q  <= '0;
				dvd_q  <= tally_nx;
			end
		end else if (dcnt_q != '0) begin
			dvx_q <= {dvx_q[SUM_W-2:0], qx};
			dvy_q <= {dvy_q[SUM_W-2:0], qy};
			rmx_q <= qx ? TALLY_W'(shx - {1'b0, dvd_q}) : shx[TALLY_W-1:0];
			rmy_q <= qy ? TALLY_W'(shy - {1'b0, dvd_q}) : shy[TALLY_W-1:0];
		end
		if (cmd.cent_load) begin
			cx_q <= sgx[COORD_W-1:0];
			cy_q <= sgy[COORD_W-1:0];
		end
	end

	// Point table.
	logic [IDX_W-1:0]       scan_idx_q;
	logic [IDX_W-1:0]       cell_idx_q [TABLE_DEPTH];
	logic [2*COORD_W-1:0]   ram_rdata;
	logic [IDX_W-1:0]       ram_raddr;

	assign ram_raddr = cmd.out_mode ? cell_idx_q[0] : scan_idx_q;

	nrps_ram #(
		.WIDTH(2 * COORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({cy_q, cx_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Distance pipeline: difference, squares, sum.
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W-1:0]        x_s2, x_s3, x_s4;
	logic [COORD_W:0]          ax_s2, ay_s2;
	logic [D2_W-1:0]           sqx_s3, sqy_s3, d2_s4;

	assign dx = {ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]} - {cx_q[COORD_W-1], cx_q};
	assign dy = {ram_rdata[2*COORD_W-1], ram_rdata[2*COORD_W-1:COORD_W]}
		- {cy_q[COORD_W-1], cy_q};

	always_ff @(posedge clk) begin
		x_s2   <= ram_rdata[COORD_W-1:0];
		ax_s2  <= dx[COORD_W] ? (~dx + (COORD_W+1)'(1)) : dx;
		ay_s2  <= dy[COORD_W] ? (~dy + (COORD_W+1)'(1)) : dy;
		x_s3   <= x_s2;
		sqx_s3 <= D2_W'(ax_s2) * D2_W'(ax_s2);
		sqy_s3 <= D2_W'(ay_s2) * D2_W'(ay_s2);
		x_s4   <= x_s3;
		d2_s4  <= sqx_s3 + sqy_s3;
	end

	// Sorted candidate list: a row of cells, each comparing its key with the new one.
	logic [D2_W-1:0]  kv;
	logic             pass, ins_go;
	logic [D2_W-1:0]  cell_key_q [TABLE_DEPTH];
	logic             cell_vld_q [TABLE_DEPTH];
	logic             gt [TABLE_DEPTH];
	logic             prv_gt [TABLE_DEPTH];
	logic [D2_W-1:0]  prv_key [TABLE_DEPTH];
	logic [IDX_W-1:0] prv_idx [TABLE_DEPTH];
	logic             prv_vld [TABLE_DEPTH];
	logic [D2_W-1:0]  nxt_key [TABLE_DEPTH];
	logic [IDX_W-1:0] nxt_idx [TABLE_DEPTH];
	logic             nxt_vld [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_q, rem_q;

	// A radius query orders by x; offset binary keeps the compare unsigned.
	assign kv = (req_q == REQ_KNN) ? d2_s4 : D2_W'({~x_s4[COORD_W-1], x_s4[COORD_W-2:0]});
	assign pass   = (req_q == REQ_KNN) || (d2_s4 <= rsq_q);
	assign ins_go = cmd.ins && pass;

	always_comb begin
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			gt[j] = !cell_vld_q[j] || (cell_key_q[j] > kv);
			if (j == 0) begin
				prv_gt[j]  = 1'b0;
				prv_key[j] = '0;
				prv_idx[j] = '0;
				prv_vld[j] = 1'b0;
			end else begin
				prv_gt[j]  = !cell_vld_q[j-1] || (cell_key_q[j-1] > kv);
				prv_key[j] = cell_key_q[j-1];
				prv_idx[j] = cell_idx_q[j-1];
				prv_vld[j] = cell_vld_q[j-1];
			end
			if (j == TABLE_DEPTH - 1) begin
				nxt_key[j] = '0;
				nxt_idx[j] = '0;
				nxt_vld[j] = 1'b0;
			end else begin
				nxt_key[j] = cell_key_q[j+1];
				nxt_idx[j] = cell_idx_q[j+1];
				nxt_vld[j] = cell_vld_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TABLE_DEPTH; j++) begin
				cell_vld_q[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < TABLE_DEPTH; j++) begin
				if (cmd.scan_init) begin
					cell_vld_q[j] <= 1'b0;
				end else if (ins_go && gt[j]) begin
					cell_vld_q[j] <= prv_gt[j] ? prv_vld[j] : 1'b1;
				end else if (cmd.emit_pt) begin
					cell_vld_q[j] <= nxt_vld[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			if (ins_go && gt[j]) begin
				cell_key_q[j] <= prv_gt[j] ? prv_key[j] : kv;
				cell_idx_q[j] <= prv_gt[j] ? prv_idx[j] : scan_idx_q;
			end else if (cmd.emit_pt) begin
				cell_key_q[j] <= nxt_key[j];
				cell_idx_q[j] <= nxt_idx[j];
			end
		end
	end

	// Results owed: all matches, capped at k for a nearest-k query.
	logic [K_W-1:0]   cnt_k, take_k;
	assign cnt_k  = K_W'(cnt_q);
	assign take_k = ((req_q == REQ_KNN) && (cnt_k > k_q)) ? k_q : cnt_k;

	// Bit-serial integer square root, two radicand bits per cycle.
	logic [D2_W-1:0]   sv_q;
	logic [34:0]       sr_q, sr_sh, trial;
	logic [DIST_W-1:0] root_q;
	logic [SCNT_W-1:0] scnt_q;
	logic              sq_ge;

	assign sr_sh = {sr_q[32:0], sv_q[D2_W-1:D2_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sq_ge = sr_sh >= trial;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sv_q   <= d2_s4;
			sr_q   <= '0;
			root_q <= '0;
		end else if (scnt_q != '0) begin
			sv_q   <= {sv_q[D2_W-3:0], 2'b00};
			sr_q   <= sq_ge ? (sr_sh - trial) : sr_sh;
			root_q <= {root_q[DIST_W-2:0], sq_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			cnt_q      <= '0;
			rem_q      <= '0;
			scnt_q     <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.emit_one && cmd.one_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.emit_one && cmd.one_clr) begin
				count_q <= '0;
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				cnt_q      <= '0;
			end else if (cmd.ins) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (pass) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.out_init) begin
				rem_q <= CNT_W'(take_k);
			end else if (cmd.emit_pt) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.sqrt_start) begin
				scnt_q <= SCNT_W'(SQ_STEPS);
			end else if (scnt_q != '0) begin
				scnt_q <= scnt_q - SCNT_W'(1);
			end
			if (cmd.emit_pt || cmd.emit_one) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pt) begin
			out_status   <= ST_OK;
			out_index    <= OIDX_W'(cell_idx_q[0]);
			out_distance <= root_q;
			out_last     <= rem_q == CNT_W'(1);
		end else if (cmd.emit_one) begin
			out_status   <= cmd.one_status;
			out_index    <= cmd.one_ins ? OIDX_W'(count_q[IDX_W-1:0]) : '0;
			out_distance <= '0;
			out_last     <= 1'b1;
		end
	end

	assign sts.div_busy  = dcnt_q != '0;
	assign sts.ovf       = ovf_req_q;
	assign sts.req       = req_q;
	assign sts.full      = count_q >= CNT_W'(TABLE_DEPTH);
	assign sts.empty     = count_q == '0;
	assign sts.scan_last = (CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q;
	assign sts.out_none  = take_k == '0;
	assign sts.out_last  = rem_q == CNT_W'(1);
	assign sts.sqrt_busy = scnt_q != '0;
	assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ hdl/nrps_chk.sv @@
`include "nearest_and_radius_point_search_top_assert.svh"

module nrps_chk import nrps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic [REQ_W-1:0]    s_tuser,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [ST_W-1:0]     m_tuser,
	input logic                m_tlast
);

	// A stalled result word stays put.
	`NRPS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Every status other than ok stands alone as the only result of its request.
	`NRPS_ASSERT_NOW(a_err_single, m_tvalid && (m_tuser != ST_OK), m_tlast)
	// While a run of results is still open, no new word is taken.
	`NRPS_ASSERT_NOW(a_busy_run, m_tvalid && !m_tlast, !s_tready)
	// Only found points carry a distance.
	`NRPS_ASSERT_NOW(a_dist_ok, m_tvalid && (m_tdata[37:6] != 32'd0), m_tuser == ST_OK)

endmodule

bind nearest_and_radius_point_search_top nrps_chk u_nrps_chk (.*);

@@ dv/nearest_and_radius_point_search_top_test.sv @@
`timescale 1ns / 100ps

module nearest_and_radius_point_search_top_test;
	import nrps_pkg::*;

	// One vertex word as the sender sees it, plus a flag that makes the sender wait
	// until every outstanding result has come back before offering this word.
	typedef struct {
		logic [REQ_W-1:0]          req;
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		logic                      closing;
		logic [K_W-1:0]            k;
		logic [RAD_W-1:0]          radius;
		bit                        drain;
	} vertex_word_t;

	// One search result word.
	typedef struct {
		logic [ST_W-1:0]   st;
		logic [OIDX_W-1:0] idx;
		logic [DIST_W-1:0] rdist;
		logic              lst;
	} match_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0]    s_tuser = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0]     m_tuser;
	logic                m_tlast;

	vertex_word_t pending_words[$];
	match_t       expected_matches[$];
	vertex_word_t word_on_bus;
	int           fail_count = 0;
	int           results_seen = 0;

	// Shadow copy of the point table and of the object accumulator.
	longint cx_tab[TABLE_DEPTH];
	longint cy_tab[TABLE_DEPTH];
	int     point_count = 0;
	longint sum_x = 0;
	longint sum_y = 0;
	int     tally = 0;
	bit     vertex_ovf = 1'b0;

	nearest_and_radius_point_search_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor square root, one result bit per pass.
	function automatic logic [DIST_W-1:0] floor_root(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[DIST_W-1:0];
	endfunction

	function automatic longint unsigned dist_sq(longint cx, longint cy, int i);
		longint dx;
		longint dy;
		longint unsigned ax;
		longint unsigned ay;
		dx = cx_tab[i] - cx;
		dy = cy_tab[i] - cy;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		return ax * ax + ay * ay;
	endfunction

	function automatic void push_match(logic [ST_W-1:0] st, int idx, logic [DIST_W-1:0] rdist,
			logic lst);
		match_t m;
		m.st = st;
		m.idx = idx[OIDX_W-1:0];
		m.rdist = rdist;
		m.lst = lst;
		expected_matches.insert(expected_matches.size(), m);
	endfunction

	// Accumulates one accepted vertex and, on a closing vertex, runs the request against
	// the shadow table and queues the results it should produce.
	function automatic void predict_search(vertex_word_t w);
		longint cx;
		longint cy;
		longint unsigned d2;
		longint unsigned kv;
		longint unsigned rr;
		longint unsigned keys[TABLE_DEPTH];
		int ord[TABLE_DEPTH];
		int cnt;
		int j;
		bit ovf;
		if (tally < MAX_VERTICES) begin
			sum_x += longint'(w.vx);
			sum_y += longint'(w.vy);
			tally++;
		end else begin
			vertex_ovf = 1'b1;
		end
		if (!w.closing)
			return;
		cx = sum_x / tally;
		cy = sum_y / tally;
		ovf = vertex_ovf;
		sum_x = 0;
		sum_y = 0;
		tally = 0;
		vertex_ovf = 1'b0;
		if (ovf) begin
			push_match(ST_OVF, 0, '0, 1'b1);
			return;
		end
		case (w.req)
			REQ_INSERT: begin
				if (point_count >= TABLE_DEPTH) begin
					push_match(ST_FULL, 0, '0, 1'b1);
				end else begin
					cx_tab[point_count] = cx;
					cy_tab[point_count] = cy;
					push_match(ST_OK, point_count, '0, 1'b1);
					point_count++;
				end
				return;
			end
			REQ_CLEAR: begin
				point_count = 0;
				push_match(ST_OK, 0, '0, 1'b1);
				return;
			end
			default: ;
		endcase
		cnt = 0;
		rr = {32'd0, w.radius} * {32'd0, w.radius};
		for (int i = 0; i < point_count; i++) begin
			d2 = dist_sq(cx, cy, i);
			if (w.req == REQ_KNN) begin
				kv = d2;
			end else begin
				if (d2 > rr)
					continue;
				// Offset x so that the signed order becomes an unsigned one.
				kv = longint'(cx_tab[i] + 64'sd1073741824);
			end
			j = cnt;
			while (j > 0 && keys[j-1] > kv) begin
				keys[j] = keys[j-1];
				ord[j] = ord[j-1];
				j--;
			end
			keys[j] = kv;
			ord[j] = i;
			cnt++;
		end
		if (w.req == REQ_KNN && cnt > w.k)
			cnt = w.k;
		if (cnt == 0) begin
			push_match(ST_NONE, 0, '0, 1'b1);
			return;
		end
		for (int i = 0; i < cnt; i++)
			push_match(ST_OK, ord[i], floor_root(dist_sq(cx, cy, ord[i])), i == cnt - 1);
	endfunction

	// Sender: offers queued words with random gaps, and predicts on every handshake.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_search(word_on_bus);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0 &&
						!(pending_words[0].drain && expected_matches.size() > 0)) begin
					word_on_bus = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, word_on_bus.radius, word_on_bus.k, word_on_bus.vy,
						word_on_bus.vx};
					s_tuser <= word_on_bus.req;
					s_tlast <= word_on_bus.closing;
					// Long bursts without gaps come from the zero case.
					if ($urandom_range(0, 19) == 0)
						send_gap = $urandom_range(10, 40);
					else if ($urandom_range(0, 1) == 0)
						send_gap = 0;
					else
						send_gap = $urandom_range(0, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls, plus one long hold-off so that the block backs up.
	int ready_gap = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				ready_gap = 1500;
			end
			if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 29) == 0)
					ready_gap = $urandom_range(15, 60);
				else if ($urandom_range(0, 2) == 0)
					ready_gap = $urandom_range(1, 3);
			end
		end
	end

	// Monitor: every accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin
		match_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected result status=%0d index=%0d distance=%0d last=%0b",
					$time, m_tuser, m_tdata[5:0], m_tdata[37:6], m_tlast);
				fail_count++;
			end else begin
				e = expected_matches.pop_front();
				if (m_tuser !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, m_tuser);
					fail_count++;
				end
				if (m_tdata[5:0] !== e.idx) begin
					$display("%0t: index expected %0d actual %0d", $time, e.idx, m_tdata[5:0]);
					fail_count++;
				end
				if (m_tdata[37:6] !== e.rdist) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.rdist,
						m_tdata[37:6]);
					fail_count++;
				end
				if (m_tlast !== e.lst) begin
					$display("%0t: last expected %0b actual %0b", $time, e.lst, m_tlast);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] pick_coord(bit wide);
		if (wide)
			return COORD_W'($urandom());
		return COORD_W'(int'($urandom_range(0, 200000)) - 100000);
	endfunction

	// Queues one object of n vertices; only the last one carries the request.
	function automatic void queue_object(logic [REQ_W-1:0] req, int n, bit wide,
			logic [K_W-1:0] k, logic [RAD_W-1:0] radius, bit drain);
		vertex_word_t w;
		for (int i = 0; i < n; i++) begin
			w.req = (i == n - 1) ? req : REQ_W'($urandom_range(0, 3));
			w.vx = pick_coord(wide);
			w.vy = pick_coord(wide);
			w.closing = (i == n - 1);
			w.k = (i == n - 1) ? k : K_W'($urandom());
			w.radius = (i == n - 1) ? radius : $urandom();
			w.drain = drain && i == 0;
			pending_words.insert(pending_words.size(), w);
		end
	endfunction

	function automatic void queue_point(logic [REQ_W-1:0] req, int x, int y,
			logic [K_W-1:0] k, logic [RAD_W-1:0] radius);
		vertex_word_t w;
		w.req = req;
		w.vx = COORD_W'(x);
		w.vy = COORD_W'(y);
		w.closing = 1'b1;
		w.k = k;
		w.radius = radius;
		w.drain = 1'b0;
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic logic [RAD_W-1:0] pick_radius();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom();
			default: return $urandom_range(0, 300000);
		endcase
	endfunction

	initial begin
		int r;
		logic [REQ_W-1:0] req;
		vertex_word_t w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: queries on an empty table, coordinate extremes, a centroid that
		// truncates toward zero, ties on distance, k of zero and beyond the table,
		// radii of zero and the maximum, and a clear.
		queue_point(REQ_KNN, 0, 0, 7'd3, 0);
		queue_point(REQ_RADIUS, 0, 0, 7'd3, 32'hFFFF_FFFF);
		queue_point(REQ_INSERT, -1073741824, 1073741823, 0, 0);
		queue_point(REQ_INSERT, 1073741823, -1073741824, 0, 0);
		w.req = REQ_INSERT; w.vx = COORD_W'(-3); w.vy = COORD_W'(5); w.closing = 1'b0;
		w.k = '0; w.radius = '0;
		w.drain = 1'b0;
		pending_words.insert(pending_words.size(), w);
		queue_point(REQ_INSERT, 0, 0, 0, 0);
		queue_point(REQ_INSERT, 2, 2, 0, 0);
		queue_point(REQ_INSERT, -2, 2, 0, 0);
		queue_point(REQ_KNN, 0, 1, 7'd0, 0);
		queue_point(REQ_KNN, 0, 1, 7'd1, 0);
		queue_point(REQ_KNN, 0, 1, 7'd127, 32'hFFFF_FFFF);
		queue_point(REQ_RADIUS, 0, 0, 0, 0);
		queue_point(REQ_RADIUS, 0, 0, 0, 32'hFFFF_FFFF);
		queue_point(REQ_RADIUS, 0, 0, 0, 3);
		queue_point(REQ_RADIUS, 500000, 500000, 0, 5);
		queue_point(REQ_CLEAR, 0, 0, 0, 0);
		queue_point(REQ_KNN, 0, 0, 7'd64, 0);

		// Fill the table to the brim after a full drain, overflow it, search it, clear it.
		queue_object(REQ_INSERT, 1, 1'b0, 0, 0, 1'b1);
		for (int i = 1; i < TABLE_DEPTH + 1; i++)
			queue_object(REQ_INSERT, 1, 1'b0, 0, 0, 1'b0);
		queue_object(REQ_KNN, 1, 1'b0, 7'd64, 0, 1'b0);
		queue_object(REQ_RADIUS, 1, 1'b0, 0, 32'd60000, 1'b0);
		queue_object(REQ_CLEAR, 1, 1'b0, 0, 0, 1'b0);

		// An object with more vertices than the accumulator takes.
		queue_object(REQ_INSERT, MAX_VERTICES + 1, 1'b1, 0, 0, 1'b0);

		// Random objects, mostly short, with random requests.
		while (pending_words.size() < 350) begin
			r = $urandom_range(0, 19);
			if (r < 8)
				req = REQ_INSERT;
			else if (r < 13)
				req = REQ_KNN;
			else if (r < 19)
				req = REQ_RADIUS;
			else
				req = REQ_CLEAR;
			queue_object(req, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) :
				$urandom_range(1, 3), $urandom_range(0, 7) == 0,
				($urandom_range(0, 15) == 0) ? K_W'($urandom()) :
				K_W'($urandom_range(1, 12)), pick_radius(), $urandom_range(0, 40) == 0);
		end

		wait (pending_words.size() == 0 && !s_tvalid && expected_matches.size() == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
